/* rtl/hva_pkg.sv */
// Shared types and constants of the homogeneous vector ALU.
package hva_pkg;

	typedef logic signed [31:0] word_t;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_NEG   = 4'd2,
		OP_SCALE = 4'd3,
		OP_DIV   = 4'd4,
		OP_PROD  = 4'd5,
		OP_DOT   = 4'd6,
		OP_CROSS = 4'd7,
		OP_MAG   = 4'd8,
		OP_NORM  = 4'd9
	} opcode_t;

	localparam word_t W_MAX = 32'sh7FFF_FFFF;
	localparam word_t W_MIN = 32'sh8000_0000;

	localparam int SQ_STEPS = 32;
	localparam int DV_STEPS = 32;

endpackage

/* rtl/hva_ifs.sv */
// Valid/ready channel interfaces for the operand and result beats.
interface hva_in_if import hva_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	word_t       a_x;
	word_t       a_y;
	word_t       a_z;
	word_t       a_w;
	word_t       b_x;
	word_t       b_y;
	word_t       b_z;
	word_t       b_w;
	word_t       scalar_in;

	modport source (
		output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
		input  ready
	);
	modport sink (
		input  valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
		output ready
	);
endinterface

interface hva_out_if import hva_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t r_x;
	word_t r_y;
	word_t r_z;
	word_t r_w;
	word_t scalar_out;
	logic  saturated;
	logic  divide_error;

	modport source (
		output valid, r_x, r_y, r_z, r_w, scalar_out, saturated, divide_error,
		input  ready
	);
	modport sink (
		input  valid, r_x, r_y, r_z, r_w, scalar_out, saturated, divide_error,
		output ready
	);
endinterface

/* rtl/homogeneous_vector_alu.sv */
// Pipelined four-component fixed-point vector ALU, top level.
//
// Usage: operand beats arrive on in_ch (opcode, tuples a and b, scalar) and
// one result beat per operand beat leaves on out_ch, in order.
// Every opcode takes the same path: 69 register stages. Throughput is one
// beat per cycle while out_ch is ready; the square root (one result bit per
// stage) and the divider (one quotient bit per stage) set the depth.
// Each stage carries its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while out_ch is stalled and
// in_ch.ready stays high until every stage holds a beat.
// An asynchronous reset clears all valid bits; no beat is in flight after it.
// Arithmetic is two's complement with FRAC_BITS fraction bits; products are
// rounded to nearest, quotients truncated, and all results saturate.
module homogeneous_vector_alu import hva_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	hva_in_if.sink     in_ch,
	hva_out_if.source  out_ch
);

	localparam int K_SQ  = 3;
	localparam int K_SU  = K_SQ + SQ_STEPS;
	localparam int K_DV  = K_SU + 1;
	localparam int K_OUT = K_DV + DV_STEPS;
	localparam int NST   = K_OUT + 1;
	localparam logic signed [66:0] RND = 67'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		opcode_t           op;
		word_t [3:0]       a;
		word_t             sc;
		word_t [3:0]       r;
		logic  [3:0]       rsat;
		logic  [5:0][63:0] p;
	} s1_t;

	typedef struct packed {
		opcode_t           op;
		word_t [3:0]       a;
		word_t             sc;
		word_t [3:0]       r;
		logic  [3:0]       rsat;
		logic  [3:0][66:0] t;
		logic  [63:0]      msq;
	} s2_t;

	typedef struct packed {
		opcode_t           op;
		word_t [3:0]       a;
		word_t             sc;
		word_t [3:0]       r;
		word_t             so;
		logic              sat;
		logic              dve;
		logic  [63:0]      sv;
		logic  [63:0]      sres;
		logic  [31:0]      den;
		logic              dz;
		logic  [3:0][32:0] rem;
		logic  [3:0][31:0] lo;
		logic  [3:0][31:0] q;
		logic  [3:0]       ovf;
		logic  [3:0]       neg;
	} item_t;

	logic [NST-1:0] vld_q;
	logic [NST:0]   en;
	logic [NST-1:0] vin;

	s1_t   f_s1, nx1;
	s2_t   f_s2, nx2;
	item_t it_s3, nx3;
	item_t sq_s [SQ_STEPS];
	item_t su_s4;
	item_t dv_s [DV_STEPS];
	item_t out_s;

	function automatic item_t sq_step(item_t x, logic [63:0] bt);
		item_t       y;
		logic [63:0] t;
		begin
			y = x;
			t = x.sres + bt;
			if (x.sv >= t) begin
				y.sv   = x.sv - t;
				y.sres = (x.sres >> 1) + bt;
			end else begin
				y.sres = x.sres >> 1;
			end
			return y;
		end
	endfunction

	function automatic item_t su_step(item_t x);
		item_t       y;
		logic [31:0] m;
		logic        msat;
		logic        dn;
		logic [31:0] absn;
		logic [63:0] nn;
		begin
			y    = x;
			m    = x.sres[31:0];
			msat = (x.sres[63:31] != '0);
			dn   = 1'b0;
			y.den = '0;
			unique case (x.op)
				OP_MAG, OP_NORM: begin
					y.so  = msat ? W_MAX : word_t'(m);
					y.sat = msat;
					if (x.op == OP_NORM) begin
						y.den = m;
					end
				end
				OP_DIV: begin
					y.den = x.sc[31] ? 32'(-x.sc) : 32'(x.sc);
					dn    = x.sc[31];
				end
				default: begin
					y.den = '0;
				end
			endcase
			y.dz = (y.den == '0);
			for (int i = 0; i < 4; i++) begin
				absn     = x.a[i][31] ? 32'(-x.a[i]) : 32'(x.a[i]);
				nn       = 64'(absn) << FRAC_BITS;
				y.rem[i] = {1'b0, nn[63:32]};
				y.lo[i]  = nn[31:0];
				y.q[i]   = '0;
				y.ovf[i] = (nn[63:32] >= y.den);
				y.neg[i] = x.a[i][31] ^ dn;
			end
			return y;
		end
	endfunction

	function automatic item_t dv_step(item_t x);
		item_t       y;
		logic [32:0] rs;
		logic        ge;
		begin
			y = x;
			for (int i = 0; i < 4; i++) begin
				rs       = {x.rem[i][31:0], x.lo[i][31]};
				ge       = (rs >= {1'b0, x.den});
				y.rem[i] = ge ? (rs - {1'b0, x.den}) : rs;
				y.lo[i]  = {x.lo[i][30:0], 1'b0};
				y.q[i]   = {x.q[i][30:0], ge};
			end
			return y;
		end
	endfunction

	function automatic item_t fin_step(item_t x);
		item_t y;
		begin
			y = x;
			if (x.op == OP_DIV || x.op == OP_NORM) begin
				for (int i = 0; i < 4; i++) begin
					if (x.dz) begin
						y.dve = 1'b1;
						if (x.a[i] == '0) begin
							y.r[i] = '0;
						end else begin
							y.r[i] = x.a[i][31] ? W_MIN : W_MAX;
							y.sat  = 1'b1;
						end
					end else if (x.ovf[i]) begin
						y.r[i] = x.neg[i] ? W_MIN : W_MAX;
						y.sat  = 1'b1;
					end else if (!x.neg[i]) begin
						if (x.q[i][31]) begin
							y.r[i] = W_MAX;
							y.sat  = 1'b1;
						end else begin
							y.r[i] = word_t'(x.q[i]);
						end
					end else begin
						if (x.q[i] > 32'h8000_0000) begin
							y.r[i] = W_MIN;
							y.sat  = 1'b1;
						end else begin
							y.r[i] = word_t'(-x.q[i]);
						end
					end
				end
			end
			return y;
		end
	endfunction

	// Stage 1: add/sub/negate and the six multipliers.
	always_comb begin
		word_t                ia [4];
		word_t                ib [4];
		word_t                isc;
		opcode_t              iop;
		logic signed [32:0]   s;
		word_t                mx [6];
		word_t                my [6];
		logic signed [63:0]   pr;
		logic                 is_x;
		logic                 is_s;
		logic                 is_m;
		ia[0] = in_ch.a_x; ia[1] = in_ch.a_y; ia[2] = in_ch.a_z; ia[3] = in_ch.a_w;
		ib[0] = in_ch.b_x; ib[1] = in_ch.b_y; ib[2] = in_ch.b_z; ib[3] = in_ch.b_w;
		isc = in_ch.scalar_in;
		iop = opcode_t'(in_ch.opcode);
		nx1.op = iop;
		nx1.sc = isc;
		for (int i = 0; i < 4; i++) begin
			nx1.a[i] = ia[i];
			unique case (iop)
				OP_ADD:  s = {ia[i][31], ia[i]} + {ib[i][31], ib[i]};
				OP_SUB:  s = {ia[i][31], ia[i]} - {ib[i][31], ib[i]};
				OP_NEG:  s = -{ia[i][31], ia[i]};
				default: s = '0;
			endcase
			nx1.rsat[i] = (s[32] != s[31]);
			nx1.r[i]    = (s[32] != s[31]) ? (s[32] ? W_MIN : W_MAX) : word_t'(s[31:0]);
		end
		is_x = (iop == OP_CROSS);
		is_s = (iop == OP_SCALE);
		is_m = (iop == OP_MAG) || (iop == OP_NORM);
		mx[0] = is_x ? ia[1] : ia[0];
		my[0] = is_x ? ib[2] : (is_s ? isc : (is_m ? ia[0] : ib[0]));
		mx[1] = is_x ? ia[2] : ia[1];
		my[1] = is_x ? ib[1] : (is_s ? isc : (is_m ? ia[1] : ib[1]));
		mx[2] = ia[2];
		my[2] = is_x ? ib[0] : (is_s ? isc : (is_m ? ia[2] : ib[2]));
		mx[3] = is_x ? ia[0] : ia[3];
		my[3] = is_x ? ib[2] : (is_s ? isc : ib[3]);
		mx[4] = ia[0];
		my[4] = ib[1];
		mx[5] = ia[1];
		my[5] = ib[0];
		for (int j = 0; j < 6; j++) begin
			pr       = mx[j] * my[j];
			nx1.p[j] = pr;
		end
	end

	// Stage 2: exact sums with the rounding constant, and the sum of squares.
	always_comb begin
		logic signed [66:0] e [6];
		for (int j = 0; j < 6; j++) begin
			e[j] = {{3{f_s1.p[j][63]}}, f_s1.p[j]};
		end
		nx2.op   = f_s1.op;
		nx2.a    = f_s1.a;
		nx2.sc   = f_s1.sc;
		nx2.r    = f_s1.r;
		nx2.rsat = f_s1.rsat;
		if (f_s1.op == OP_CROSS) begin
			nx2.t[0] = e[0] - e[1] + RND;
			nx2.t[1] = e[2] - e[3] + RND;
			nx2.t[2] = e[4] - e[5] + RND;
		end else if (f_s1.op == OP_DOT) begin
			nx2.t[0] = e[0] + e[1] + e[2] + e[3] + RND;
			nx2.t[1] = e[1] + RND;
			nx2.t[2] = e[2] + RND;
		end else begin
			nx2.t[0] = e[0] + RND;
			nx2.t[1] = e[1] + RND;
			nx2.t[2] = e[2] + RND;
		end
		nx2.t[3] = e[3] + RND;
		nx2.msq  = f_s1.p[0] + f_s1.p[1] + f_s1.p[2];
	end

	// Stage 3: rounding shift, saturation and result selection.
	always_comb begin
		logic signed [66:0] sh;
		word_t              rv [4];
		logic  [3:0]        rst;
		for (int i = 0; i < 4; i++) begin
			sh     = $signed(f_s2.t[i]) >>> FRAC_BITS;
			rst[i] = (sh[66:31] != {36{sh[31]}});
			rv[i]  = rst[i] ? (sh[66] ? W_MIN : W_MAX) : word_t'(sh[31:0]);
		end
		nx3      = '0;
		nx3.op   = f_s2.op;
		nx3.a    = f_s2.a;
		nx3.sc   = f_s2.sc;
		nx3.sv   = f_s2.msq;
		unique case (f_s2.op)
			OP_ADD, OP_SUB, OP_NEG: begin
				nx3.r   = f_s2.r;
				nx3.sat = |f_s2.rsat;
			end
			OP_SCALE, OP_PROD: begin
				for (int i = 0; i < 4; i++) begin
					nx3.r[i] = rv[i];
				end
				nx3.sat = |rst;
			end
			OP_DOT: begin
				nx3.so  = rv[0];
				nx3.sat = rst[0];
			end
			OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					nx3.r[i] = rv[i];
				end
				nx3.sat = |rst[2:0];
			end
			default: begin
				nx3.sat = 1'b0;
			end
		endcase
	end

	assign vin      = {vld_q[NST-2:0], in_ch.valid};
	assign en[NST]  = out_ch.ready;
	assign in_ch.ready = en[0];

	for (genvar k = 0; k < NST; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			f_s1 <= nx1;
		end
		if (en[1]) begin
			f_s2 <= nx2;
		end
		if (en[2]) begin
			it_s3 <= nx3;
		end
		if (en[K_SU]) begin
			su_s4 <= su_step(sq_s[SQ_STEPS-1]);
		end
		if (en[K_OUT]) begin
			out_s <= fin_step(dv_s[DV_STEPS-1]);
		end
	end

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
		item_t src;
		if (j == 0) begin : g_first
			assign src = it_s3;
		end else begin : g_rest
			assign src = sq_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en[K_SQ+j]) begin
				sq_s[j] <= sq_step(src, 64'd1 << (62 - 2 * j));
			end
		end
	end

	for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
		item_t src;
		if (j == 0) begin : g_first
			assign src = su_s4;
		end else begin : g_rest
			assign src = dv_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en[K_DV+j]) begin
				dv_s[j] <= dv_step(src);
			end
		end
	end

	assign out_ch.valid        = vld_q[NST-1];
	assign out_ch.r_x          = out_s.r[0];
	assign out_ch.r_y          = out_s.r[1];
	assign out_ch.r_z          = out_s.r[2];
	assign out_ch.r_w          = out_s.r[3];
	assign out_ch.scalar_out   = out_s.so;
	assign out_ch.saturated    = out_s.sat;
	assign out_ch.divide_error = out_s.dve;

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> vld_q[0])
		else $error("Accepted beat did not enter the first stage.");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (&vld_q) && !out_ch.ready)
		else $error("Input held off while the pipeline has room.");

	a_dve_op: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.divide_error |-> (out_s.op == OP_DIV || out_s.op == OP_NORM))
		else $error("Divide error raised by an operation without a division.");

	a_mag_tuple: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_s.op == OP_MAG |->
			out_ch.r_x == '0 && out_ch.r_w == '0 && !out_ch.divide_error)
		else $error("Magnitude beat carries a tuple or an error.");

endmodule
